/* sv/tcce_pkg.sv */
// Shared constants for the text console character engine.
// No dependencies; imported by the top level.
`default_nettype none

package tcce_pkg;

    // Default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Character codes
    localparam logic [7:0] SPACE_CODE     = 8'h20;
    localparam logic [7:0] CODE_NEWLINE   = 8'd10;
    localparam logic [7:0] CODE_RETURN    = 8'd13;
    localparam logic [7:0] CODE_TAB       = 8'd9;
    localparam logic [7:0] CODE_BACKSPACE = 8'd8;

    // Tab stops fall on multiples of a power of two
    localparam int TAB_STOP   = 4;
    localparam int TAB_MASK_W = $clog2(TAB_STOP);
    localparam int TAB_CNT_W  = TAB_MASK_W + 1;

    // Attribute register and the blank the store holds after reset
    localparam logic [7:0]  ATTR_RESET  = 8'h0F;
    localparam logic [15:0] RESET_BLANK = {ATTR_RESET, SPACE_CODE};

    // Request kinds
    localparam logic [1:0] ACT_PUT  = 2'd0;
    localparam logic [1:0] ACT_SET  = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;
    localparam logic [1:0] ACT_NONE = 2'd3;

    // Register map
    localparam logic REG_ATTRIBUTE = 1'b0;
    localparam int   APB_ADDR_W    = 3;

endpackage

`default_nettype wire

/* sv/tcce_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// Stand-alone; no package needed.
`default_nettype none

module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* sv/text_console_character_engine_unit.sv */
// Top level of the text console character engine: cursor, scroll and
// request sequencer around a single screen RAM. Uses tcce_pkg and tcce_ram.
`default_nettype none

// Text console engine. Requests carry a kind in s_axis_tuser (put character,
// set cursor, read cell) and return exactly one result holding the cell read
// (zero for other kinds) and the cursor after the request. All screen cells
// live in one RAM with one write and one read port, so cells are written one
// at a time. A tab writes spaces up to the next tab stop. A pending wrap is
// taken before a write. A scroll blanks the new bottom row one cell per cycle.
// After reset all ROWS*COLUMNS cells of the RAM are swept to blanks, during
// which no request is taken; the attribute register can be written meanwhile.
// A finished result waits in the output register while the next request is
// taken.
module text_console_character_engine_unit #(
    parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcce_pkg::ROWS_DEF,
    parameter int COL_W   = $clog2(COLUMNS + 1),
    parameter int ROW_W   = $clog2(ROWS),
    parameter int IN_TD_W  = 8 * ((8 + COL_W + ROW_W + 7) / 8),
    parameter int OUT_TD_W = 8 * ((16 + COL_W + ROW_W + 7) / 8)
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // request stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [IN_TD_W-1:0]                s_axis_tdata,  // char_code, col, row
    input  wire logic [1:0]                        s_axis_tuser,  // action
    // result stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic      [OUT_TD_W-1:0]               m_axis_tdata,  // cell_value, cursor_col, cursor_row
    // configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [tcce_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                       pwdata,
    output logic      [31:0]                       prdata,
    output logic                                   pready
);

    import tcce_pkg::*;

    localparam int CELLS   = COLUMNS * ROWS;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int SCNT_W  = $clog2(COLUMNS);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_PRINT  = 3'd3;
    localparam logic [2:0] ST_SCROLL = 3'd4;
    localparam logic [2:0] ST_READ   = 3'd5;
    localparam logic [2:0] ST_WAIT   = 3'd6;

    logic [2:0]           state_reg, state_next;
    logic [ADDR_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [1:0]           act_reg, act_next;
    logic [7:0]           code_reg, code_next;
    logic [COL_W-1:0]     col_in_reg, col_in_next;
    logic [ROW_W-1:0]     row_in_reg, row_in_next;
    logic [COL_W-1:0]     cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]     cur_line_reg, cur_line_next;
    logic [ROW_W-1:0]     top_reg, top_next;
    logic [7:0]           attr_reg, attr_next;
    logic [TAB_CNT_W-1:0] print_cnt_reg, print_cnt_next;
    logic [7:0]           print_code_reg, print_code_next;
    logic [SCNT_W-1:0]    scroll_cnt_reg, scroll_cnt_next;
    logic [ROW_W-1:0]     scroll_row_reg, scroll_row_next;
    logic                 scroll_ret_reg, scroll_ret_next;
    logic [15:0]          cell_reg, cell_next;
    logic                 out_valid_reg, out_valid_next;
    logic [15:0]          out_cell_reg, out_cell_next;
    logic [COL_W-1:0]     out_col_reg, out_col_next;
    logic [ROW_W-1:0]     out_row_reg, out_row_next;

    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [15:0]          wr_data;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic [15:0]          rd_data;

    logic                 in_accept;
    logic                 out_free;
    logic                 done;
    logic [15:0]          res_cell;
    logic                 req_in_range;
    logic                 cfg_write;
    logic [ADDR_W-1:0]    cur_addr;
    logic [ADDR_W-1:0]    req_addr;
    logic [ROW_W-1:0]     top_inc;

    // Physical cell address of a logical row and column on the circular screen
    function automatic logic [ADDR_W-1:0] addr_of(
        input logic [ROW_W-1:0] top,
        input logic [ROW_W-1:0] line,
        input logic [COL_W-1:0] column
    );
        logic [ROW_W:0] sum;
        sum = {1'b0, top} + {1'b0, line};
        if (sum >= (ROW_W + 1)'(ROWS))
        begin
            sum = sum - (ROW_W + 1)'(ROWS);
        end
        return ADDR_W'(sum[ROW_W-1:0]) * ADDR_W'(COLUMNS) + ADDR_W'(column);
    endfunction

    tcce_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_screen_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TD_W'({out_row_reg, out_col_reg, out_cell_reg});

    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_ATTRIBUTE) ? {24'd0, attr_reg} : 32'd0;
    assign attr_next = (cfg_write && paddr[2] == REG_ATTRIBUTE) ? pwdata[7:0] : attr_reg;

    assign req_in_range = (col_in_reg < COL_W'(COLUMNS))
                       && ({1'b0, row_in_reg} < (ROW_W + 1)'(ROWS));
    assign cur_addr = addr_of(top_reg, cur_line_reg, cur_col_reg);
    assign req_addr = addr_of(top_reg, row_in_reg, col_in_reg);
    assign top_inc  = (top_reg == ROW_W'(ROWS - 1)) ? '0 : top_reg + ROW_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        act_next        = act_reg;
        code_next       = code_reg;
        col_in_next     = col_in_reg;
        row_in_next     = row_in_reg;
        cur_col_next    = cur_col_reg;
        cur_line_next   = cur_line_reg;
        top_next        = top_reg;
        print_cnt_next  = print_cnt_reg;
        print_code_next = print_code_reg;
        scroll_cnt_next = scroll_cnt_reg;
        scroll_row_next = scroll_row_reg;
        scroll_ret_next = scroll_ret_reg;
        cell_next       = cell_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_cell_next   = out_cell_reg;
        out_col_next    = out_col_reg;
        out_row_next    = out_row_reg;
        wr_en           = 1'b0;
        wr_addr         = cur_addr;
        wr_data         = {attr_reg, SPACE_CODE};
        rd_en           = 1'b0;
        rd_addr         = req_addr;
        done            = 1'b0;
        res_cell        = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_data = RESET_BLANK;
                if (clr_cnt_reg == ADDR_W'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (in_accept)
                begin
                    act_next    = s_axis_tuser;
                    code_next   = s_axis_tdata[7:0];
                    col_in_next = s_axis_tdata[8 +: COL_W];
                    row_in_next = s_axis_tdata[8 + COL_W +: ROW_W];
                    state_next  = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                unique case (act_reg)
                    ACT_PUT:
                    begin
                        unique case (code_reg)
                            CODE_NEWLINE:
                            begin
                                cur_col_next = '0;
                                if (cur_line_reg == ROW_W'(ROWS - 1))
                                begin
                                    top_next        = top_inc;
                                    scroll_row_next = top_reg;
                                    scroll_cnt_next = '0;
                                    scroll_ret_next = 1'b0;
                                    state_next      = ST_SCROLL;
                                end
                                else
                                begin
                                    cur_line_next = cur_line_reg + ROW_W'(1);
                                    done          = 1'b1;
                                end
                            end
                            CODE_RETURN:
                            begin
                                cur_col_next = '0;
                                done         = 1'b1;
                            end
                            CODE_TAB:
                            begin
                                print_cnt_next  = TAB_CNT_W'(TAB_STOP)
                                                - TAB_CNT_W'(cur_col_reg[TAB_MASK_W-1:0]);
                                print_code_next = SPACE_CODE;
                                state_next      = ST_PRINT;
                            end
                            CODE_BACKSPACE:
                            begin
                                if (cur_col_reg != '0)
                                begin
                                    cur_col_next = cur_col_reg - COL_W'(1);
                                    wr_en        = 1'b1;
                                    wr_addr      = addr_of(top_reg, cur_line_reg, cur_col_next);
                                end
                                done = 1'b1;
                            end
                            default:
                            begin
                                print_cnt_next  = TAB_CNT_W'(1);
                                print_code_next = code_reg;
                                state_next      = ST_PRINT;
                            end
                        endcase
                    end
                    ACT_SET:
                    begin
                        if (req_in_range)
                        begin
                            cur_col_next  = col_in_reg;
                            cur_line_next = row_in_reg;
                        end
                        done = 1'b1;
                    end
                    ACT_READ:
                    begin
                        if (req_in_range)
                        begin
                            rd_en      = 1'b1;
                            state_next = ST_READ;
                        end
                        else
                        begin
                            done = 1'b1;
                        end
                    end
                    ACT_NONE:
                    begin
                        done = 1'b1;
                    end
                endcase
            end

            ST_PRINT:
            begin
                if (cur_col_reg == COL_W'(COLUMNS))
                begin
                    // pending wrap: take the newline first, scroll before writing
                    cur_col_next = '0;
                    if (cur_line_reg == ROW_W'(ROWS - 1))
                    begin
                        top_next        = top_inc;
                        scroll_row_next = top_reg;
                        scroll_cnt_next = '0;
                        scroll_ret_next = 1'b1;
                        state_next      = ST_SCROLL;
                    end
                    else
                    begin
                        cur_line_next = cur_line_reg + ROW_W'(1);
                    end
                end
                else
                begin
                    wr_en          = 1'b1;
                    wr_data        = {attr_reg, print_code_reg};
                    cur_col_next   = cur_col_reg + COL_W'(1);
                    print_cnt_next = print_cnt_reg - TAB_CNT_W'(1);
                    if (print_cnt_reg == TAB_CNT_W'(1))
                    begin
                        done = 1'b1;
                    end
                end
            end

            ST_SCROLL:
            begin
                // old top row becomes the new bottom row
                wr_en   = 1'b1;
                wr_addr = ADDR_W'(scroll_row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(scroll_cnt_reg);
                if (scroll_cnt_reg == SCNT_W'(COLUMNS - 1))
                begin
                    if (scroll_ret_reg)
                    begin
                        state_next = ST_PRINT;
                    end
                    else
                    begin
                        done = 1'b1;
                    end
                end
                else
                begin
                    scroll_cnt_next = scroll_cnt_reg + SCNT_W'(1);
                end
            end

            ST_READ:
            begin
                res_cell = rd_data;
                done     = 1'b1;
            end

            ST_WAIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_cell_next  = cell_reg;
                    out_col_next   = cur_col_reg;
                    out_row_next   = cur_line_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Finished request: hand the result over now or hold it until taken
        if (done)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                out_cell_next  = res_cell;
                out_col_next   = cur_col_next;
                out_row_next   = cur_line_next;
                state_next     = ST_IDLE;
            end
            else
            begin
                cell_next  = res_cell;
                state_next = ST_WAIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            cur_col_reg    <= '0;
            cur_line_reg   <= '0;
            top_reg        <= '0;
            attr_reg       <= ATTR_RESET;
            print_cnt_reg  <= '0;
            scroll_cnt_reg <= '0;
            scroll_ret_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            cur_col_reg    <= cur_col_next;
            cur_line_reg   <= cur_line_next;
            top_reg        <= top_next;
            attr_reg       <= attr_next;
            print_cnt_reg  <= print_cnt_next;
            scroll_cnt_reg <= scroll_cnt_next;
            scroll_ret_reg <= scroll_ret_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        code_reg       <= code_next;
        col_in_reg     <= col_in_next;
        row_in_reg     <= row_in_next;
        print_code_reg <= print_code_next;
        scroll_row_reg <= scroll_row_next;
        cell_reg       <= cell_next;
        out_cell_reg   <= out_cell_next;
        out_col_reg    <= out_col_next;
        out_row_reg    <= out_row_next;
    end

    // Cursor stays on screen; column may rest at COLUMNS only as a pending wrap
    a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_col_reg <= COL_W'(COLUMNS)) && ({1'b0, cur_line_reg} < (ROW_W + 1)'(ROWS)))
        else $error("cursor left the screen");

    // Read data is consumed in the cycle after the read was issued
    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> $past(rd_en))
        else $error("read data used without a read");

    // The top row moves only when a scroll pass starts
    a_top_moves_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        (top_reg != $past(top_reg)) |-> (state_reg == ST_SCROLL) && (scroll_cnt_reg == '0))
        else $error("top row moved outside a scroll");

    // A result is held back only while the output register is full; no request is taken meanwhile
    a_no_accept_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT) |-> out_valid_reg)
        else $error("held result with empty output register");

    // The RAM is never written while the sequencer is idle or waiting
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg != ST_IDLE) && (state_reg != ST_WAIT))
        else $error("screen write outside a request");

endmodule

`default_nettype wire
